### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// Each macro wraps one concurrent assertion clocked on a rising edge, with active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every edge outside reset
`define ASSERT_CLK_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// when ante holds, cons must hold at the next edge
`define ASSERT_NEXT_RST(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/mck_pkg.sv
// Package for the Morse character keyer: descriptor type, interval lengths, code lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam logic [2:0] DOT_UNITS        = 3'd1;
    localparam logic [2:0] DASH_UNITS       = 3'd3;
    localparam logic [2:0] SYMBOL_GAP_UNITS = 3'd1;
    localparam logic [2:0] LETTER_GAP_UNITS = 3'd2;
    localparam logic [2:0] WORD_GAP_UNITS   = 3'd6;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // pat[0] is the first symbol sent, 1 = dash
    typedef struct packed {
        logic       space;
        logic [2:0] len;
        logic [4:0] pat;
    } mck_desc_t;

    function automatic mck_desc_t mck_classify(input logic [7:0] code);
        logic [7:0] uc;
        mck_desc_t  d;
        uc = ((code >= CHAR_LOWER_A) && (code <= CHAR_LOWER_Z)) ? (code - CASE_OFFSET) : code;
        d.space = (code == CHAR_SPACE);
        d.len   = 3'd0;
        d.pat   = 5'b00000;
        unique case (uc)
            8'h41: begin d.len = 3'd2; d.pat = 5'b00010; end // A
            8'h42: begin d.len = 3'd4; d.pat = 5'b00001; end // B
            8'h43: begin d.len = 3'd4; d.pat = 5'b00101; end // C
            8'h44: begin d.len = 3'd3; d.pat = 5'b00001; end // D
            8'h45: begin d.len = 3'd1; d.pat = 5'b00000; end // E
            8'h46: begin d.len = 3'd4; d.pat = 5'b00100; end // F
            8'h47: begin d.len = 3'd3; d.pat = 5'b00011; end // G
            8'h48: begin d.len = 3'd4; d.pat = 5'b00000; end // H
            8'h49: begin d.len = 3'd2; d.pat = 5'b00000; end // I
            8'h4A: begin d.len = 3'd4; d.pat = 5'b01110; end // J
            8'h4B: begin d.len = 3'd3; d.pat = 5'b00101; end // K
            8'h4C: begin d.len = 3'd4; d.pat = 5'b00010; end // L
            8'h4D: begin d.len = 3'd2; d.pat = 5'b00011; end // M
            8'h4E: begin d.len = 3'd2; d.pat = 5'b00001; end // N
            8'h4F: begin d.len = 3'd3; d.pat = 5'b00111; end // O
            8'h50: begin d.len = 3'd4; d.pat = 5'b00110; end // P
            8'h51: begin d.len = 3'd4; d.pat = 5'b01011; end // Q
            8'h52: begin d.len = 3'd3; d.pat = 5'b00010; end // R
            8'h53: begin d.len = 3'd3; d.pat = 5'b00000; end // S
            8'h54: begin d.len = 3'd1; d.pat = 5'b00001; end // T
            8'h55: begin d.len = 3'd3; d.pat = 5'b00100; end // U
            8'h56: begin d.len = 3'd4; d.pat = 5'b01000; end // V
            8'h57: begin d.len = 3'd3; d.pat = 5'b00110; end // W
            8'h58: begin d.len = 3'd4; d.pat = 5'b01001; end // X
            8'h59: begin d.len = 3'd4; d.pat = 5'b01101; end // Y
            8'h5A: begin d.len = 3'd4; d.pat = 5'b00011; end // Z
            8'h30: begin d.len = 3'd5; d.pat = 5'b11111; end // 0
            8'h31: begin d.len = 3'd5; d.pat = 5'b11110; end // 1
            8'h32: begin d.len = 3'd5; d.pat = 5'b11100; end // 2
            8'h33: begin d.len = 3'd5; d.pat = 5'b11000; end // 3
            8'h34: begin d.len = 3'd5; d.pat = 5'b10000; end // 4
            8'h35: begin d.len = 3'd5; d.pat = 5'b00000; end // 5
            8'h36: begin d.len = 3'd5; d.pat = 5'b00001; end // 6
            8'h37: begin d.len = 3'd5; d.pat = 5'b00011; end // 7
            8'h38: begin d.len = 3'd5; d.pat = 5'b00111; end // 8
            8'h39: begin d.len = 3'd5; d.pat = 5'b01111; end // 9
            default: begin d.len = 3'd0; d.pat = 5'b00000; end
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### rtl/core/morse_character_keyer_top.sv
// Top level of the Morse character keyer: front classifier, descriptor queue, interval sequencer.
// Depends on mck_pkg, mck_front, mck_queue, mck_back.
//
//  channel | direction | ports                                     | one item
//  s_      | in        | s_valid s_ready s_char_code               | one character
//  m_      | out       | m_valid m_ready m_key_level               | one keying interval
//          |           | m_duration_units m_last_interval          |
//
// A character of n symbols gives 2n+1 intervals, one per unstalled cycle from the sequencer.
// Space and unknown codes give one interval. A character passes front, queue and sequencer registers.
// The front takes a character every cycle while the queue (QUEUE_DEPTH entries) has room.
// Synchronous active-low reset empties all stages; either side may stall at any time.
`timescale 1ns / 1ps
`default_nettype none

module morse_character_keyer_top #(
    parameter int unsigned QUEUE_DEPTH = mck_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_key_level,
    output logic [2:0]      m_duration_units,
    output logic            m_last_interval
);

    logic               push_valid;
    logic               push_ready;
    mck_pkg::mck_desc_t push_desc;
    logic               pop_valid;
    logic               pop_ready;
    mck_pkg::mck_desc_t pop_desc;

    mck_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_code (s_char_code),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_desc   (push_desc)
    );

    mck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_desc),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_desc)
    );

    mck_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_desc         (pop_desc),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_key_level      (m_key_level),
        .m_duration_units (m_duration_units),
        .m_last_interval  (m_last_interval)
    );

endmodule

`default_nettype wire

### rtl/core/mck_front.sv
// Front stage: accepts character items, classifies them into descriptors, one register stage.
// Depends on mck_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mck_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [7:0]        s_char_code,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output mck_pkg::mck_desc_t     push_desc
);

    logic               valid_reg;
    logic               valid_next;
    mck_pkg::mck_desc_t desc_reg;
    mck_pkg::mck_desc_t desc_next;
    logic               take;

    assign s_ready    = !valid_reg || push_ready;
    assign take       = s_valid && s_ready;
    assign push_valid = valid_reg;
    assign push_desc  = desc_reg;

    always_comb begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        if (take) begin
            valid_next = 1'b1;
            desc_next  = mck_pkg::mck_classify(s_char_code);
        end else if (push_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
    end

endmodule

`default_nettype wire

### rtl/core/mck_queue.sv
// Descriptor queue between front and back stages, first in first out.
// Depends on mck_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mck_queue #(
    parameter int unsigned DEPTH = mck_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire mck_pkg::mck_desc_t  wr_data,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output mck_pkg::mck_desc_t       rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mck_pkg::mck_desc_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wr_fire;
    logic               rd_fire;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_fire && !rd_fire) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rd_fire && !wr_fire) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mck_back.sv
// Back stage: walks a descriptor into an output register, one interval per unstalled cycle.
// Depends on mck_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mck_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                pop_valid,
    output logic                     pop_ready,
    input  wire mck_pkg::mck_desc_t  pop_desc,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_key_level,
    output logic [2:0]               m_duration_units,
    output logic                     m_last_interval
);

    logic       cur_valid_reg, cur_valid_next;
    logic       space_reg, space_next;
    logic [2:0] rem_reg, rem_next;
    logic [4:0] pat_reg, pat_next;
    logic       gap_reg, gap_next;

    logic       m_valid_reg, m_valid_next;
    logic       level_reg, level_next;
    logic [2:0] units_reg, units_next;
    logic       last_reg, last_next;

    logic       adv;
    logic       emit;
    logic       done;
    logic       iv_level;
    logic [2:0] iv_units;
    logic       iv_last;

    assign adv       = !m_valid_reg || m_ready;
    assign emit      = adv && cur_valid_reg;
    assign done      = space_reg || (rem_reg == 3'd0);
    assign pop_ready = !cur_valid_reg || (emit && done);

    assign m_valid          = m_valid_reg;
    assign m_key_level      = level_reg;
    assign m_duration_units = units_reg;
    assign m_last_interval  = last_reg;

    // interval for the current position
    always_comb begin
        if (space_reg) begin
            iv_level = 1'b0;
            iv_units = mck_pkg::WORD_GAP_UNITS;
            iv_last  = 1'b1;
        end else if (rem_reg == 3'd0) begin
            iv_level = 1'b0;
            iv_units = mck_pkg::LETTER_GAP_UNITS;
            iv_last  = 1'b1;
        end else if (!gap_reg) begin
            iv_level = 1'b1;
            iv_units = pat_reg[0] ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS;
            iv_last  = 1'b0;
        end else begin
            iv_level = 1'b0;
            iv_units = mck_pkg::SYMBOL_GAP_UNITS;
            iv_last  = 1'b0;
        end
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        space_next     = space_reg;
        rem_next       = rem_reg;
        pat_next       = pat_reg;
        gap_next       = gap_reg;
        m_valid_next   = m_valid_reg;
        level_next     = level_reg;
        units_next     = units_reg;
        last_next      = last_reg;

        if (emit) begin
            m_valid_next = 1'b1;
            level_next   = iv_level;
            units_next   = iv_units;
            last_next    = iv_last;
            if (done) begin
                cur_valid_next = 1'b0;
            end else if (!gap_reg) begin
                gap_next = 1'b1;
            end else begin
                gap_next = 1'b0;
                rem_next = rem_reg - 3'd1;
                pat_next = {1'b0, pat_reg[4:1]};
            end
        end else if (adv) begin
            m_valid_next = 1'b0;
        end

        if (pop_valid && pop_ready) begin
            cur_valid_next = 1'b1;
            space_next     = pop_desc.space;
            rem_next       = pop_desc.len;
            pat_next       = pop_desc.pat;
            gap_next       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        space_reg <= space_next;
        rem_reg   <= rem_next;
        pat_reg   <= pat_next;
        gap_reg   <= gap_next;
        level_reg <= level_next;
        units_reg <= units_next;
        last_reg  <= last_next;
    end

endmodule

`default_nettype wire

### rtl/core/mck_checker.sv
// Port-level checks on the keyer's result channel, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mck_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic [7:0] s_char_code,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_key_level,
    input wire logic [2:0] m_duration_units,
    input wire logic       m_last_interval
);

    logic unused_in;
    assign unused_in = s_valid ^ s_ready ^ (^s_char_code);

    `ASSERT_CLK_RST(a_mark_not_last, aclk, aresetn, !(m_valid && m_key_level) || !m_last_interval, "key-on interval flagged last")
    `ASSERT_CLK_RST(a_mark_units, aclk, aresetn, !(m_valid && m_key_level) || m_duration_units == 3'd1 || m_duration_units == 3'd3, "bad key-on length")
    `ASSERT_CLK_RST(a_space_units, aclk, aresetn, !(m_valid && !m_key_level) || m_duration_units == 3'd1 || m_duration_units == 3'd2 || m_duration_units == 3'd6, "bad key-off length")
    `ASSERT_CLK_RST(a_gap_last, aclk, aresetn, !(m_valid && m_duration_units != 3'd1 && !m_key_level) || m_last_interval, "closing gap not flagged last")
    `ASSERT_NEXT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_key_level) && $stable(m_duration_units) && $stable(m_last_interval), "stalled item changed")

endmodule

bind morse_character_keyer_top mck_checker u_mck_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_char_code      (s_char_code),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_key_level      (m_key_level),
    .m_duration_units (m_duration_units),
    .m_last_interval  (m_last_interval)
);

`default_nettype wire

### sim/tb_morse_character_keyer_top.sv
// Self-checking testbench for morse_character_keyer_top: drives characters, predicts intervals.
// Depends on mck_pkg and the keyer RTL; directed table first, then random traffic with stalls.
`timescale 1ns / 1ps

module tb_morse_character_keyer_top;

    localparam int CLK_PERIOD      = 8;
    localparam int IDLE_PCT        = 30;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int NUM_DIRECTED    = 24;

    typedef struct packed {
        logic       key;
        logic [2:0] units;
        logic       last;
    } interval_t;

    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        interval_t  iv;
    } char_row_t;

    localparam interval_t WORD_GAP_ONLY   = {1'b0, mck_pkg::WORD_GAP_UNITS, 1'b1};
    localparam interval_t LETTER_GAP_ONLY = {1'b0, mck_pkg::LETTER_GAP_UNITS, 1'b1};
    localparam interval_t NO_IV           = '0;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_code;
    logic       m_valid;
    logic       m_ready;
    logic       m_key_level;
    logic [2:0] m_duration_units;
    logic       m_last_interval;

    interval_t  expected_intervals[$];
    interval_t  want_iv;
    int         error_count;
    int         quiet_cycles;
    bit         idle_on;
    bit         hold_request;

    // single-interval rows are typed in; the rest go through the predictor
    char_row_t directed_rows [NUM_DIRECTED] = '{
        '{8'h20, 1'b1, WORD_GAP_ONLY},
        '{8'h00, 1'b1, LETTER_GAP_ONLY},
        '{8'hFF, 1'b1, LETTER_GAP_ONLY},
        '{8'h80, 1'b1, LETTER_GAP_ONLY},
        '{8'h7F, 1'b1, LETTER_GAP_ONLY},
        '{8'h40, 1'b1, LETTER_GAP_ONLY},
        '{8'h5B, 1'b1, LETTER_GAP_ONLY},
        '{8'h60, 1'b1, LETTER_GAP_ONLY},
        '{8'h7B, 1'b1, LETTER_GAP_ONLY},
        '{8'h2F, 1'b1, LETTER_GAP_ONLY},
        '{8'h3A, 1'b1, LETTER_GAP_ONLY},
        '{8'h1F, 1'b1, LETTER_GAP_ONLY},
        '{8'h41, 1'b0, NO_IV},
        '{8'h5A, 1'b0, NO_IV},
        '{8'h61, 1'b0, NO_IV},
        '{8'h7A, 1'b0, NO_IV},
        '{8'h30, 1'b0, NO_IV},
        '{8'h39, 1'b0, NO_IV},
        '{8'h35, 1'b0, NO_IV},
        '{8'h45, 1'b0, NO_IV},
        '{8'h54, 1'b0, NO_IV},
        '{8'h51, 1'b0, NO_IV},
        '{8'h68, 1'b0, NO_IV},
        '{8'h31, 1'b0, NO_IV}
    };

    morse_character_keyer_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_key_level      (m_key_level),
        .m_duration_units (m_duration_units),
        .m_last_interval  (m_last_interval)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic string morse_symbols(input logic [7:0] uc);
        case (uc)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    task automatic predict_intervals(input logic [7:0] code);
        logic [7:0] uc;
        string      sym;
        if (code == mck_pkg::CHAR_SPACE) begin
            expected_intervals.push_back({1'b0, mck_pkg::WORD_GAP_UNITS, 1'b1});
            return;
        end
        uc = (code >= mck_pkg::CHAR_LOWER_A && code <= mck_pkg::CHAR_LOWER_Z) ?
             code - mck_pkg::CASE_OFFSET : code;
        sym = morse_symbols(uc);
        for (int i = 0; i < sym.len(); i++) begin
            expected_intervals.push_back({1'b1,
                (sym[i] == "-") ? mck_pkg::DASH_UNITS : mck_pkg::DOT_UNITS, 1'b0});
            expected_intervals.push_back({1'b0, mck_pkg::SYMBOL_GAP_UNITS, 1'b0});
        end
        expected_intervals.push_back({1'b0, mck_pkg::LETTER_GAP_UNITS, 1'b1});
    endtask

    task automatic send_char(input logic [7:0] code, input logic typed, input interval_t iv);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_char_code <= code;
        do @(posedge aclk); while (!s_ready);
        if (typed)
            expected_intervals.push_back(iv);
        else
            predict_intervals(code);
    endtask

    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return 8'(8'h41 + $urandom_range(25));
        else if (pick < 45)
            return 8'(8'h61 + $urandom_range(25));
        else if (pick < 60)
            return 8'(8'h30 + $urandom_range(9));
        else if (pick < 70)
            return mck_pkg::CHAR_SPACE;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_char(random_char(), 1'b0, NO_IV);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_intervals.size() == 0) begin
                report_mismatch($sformatf("unexpected interval key=%0b units=%0d last=%0b",
                                          m_key_level, m_duration_units, m_last_interval));
            end else begin
                want_iv = expected_intervals.pop_front();
                if (m_key_level !== want_iv.key)
                    report_mismatch($sformatf("key_level %0b, want %0b",
                                              m_key_level, want_iv.key));
                if (m_duration_units !== want_iv.units)
                    report_mismatch($sformatf("duration_units %0d, want %0d",
                                              m_duration_units, want_iv.units));
                if (m_last_interval !== want_iv.last)
                    report_mismatch($sformatf("last_interval %0b, want %0b",
                                              m_last_interval, want_iv.last));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("TIMEOUT: no item moved for %0d cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        error_count  = 0;
        quiet_cycles = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_char_code  <= 8'h00;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_char(directed_rows[i].code, directed_rows[i].typed, directed_rows[i].iv);

        send_random(150);

        // receiver holds off while the sender keeps offering
        hold_request = 1'b1;
        send_random(60);

        idle_on = 1'b0;
        send_random(100);
        idle_on = 1'b1;
        send_random(150);

        s_valid <= 1'b0;
        while (expected_intervals.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### morse_character_keyer_top.f
+incdir+rtl/core
rtl/core/mck_pkg.sv
rtl/core/mck_front.sv
rtl/core/mck_queue.sv
rtl/core/mck_back.sv
rtl/core/morse_character_keyer_top.sv
rtl/core/mck_checker.sv
sim/tb_morse_character_keyer_top.sv
